FILE: rtl/ray_box_slab_test_assert.svh
// assertion helpers for the ray box slab test
`ifndef RAY_BOX_SLAB_TEST_ASSERT_SVH
`define RAY_BOX_SLAB_TEST_ASSERT_SVH

`ifndef SYNTHESIS
`define RBST_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("assertion failed");
`define RBST_ASSERT_NOW(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("assertion failed");
`else
`define RBST_ASSERT_NEXT(label, clk, rst_n, a, b)
`define RBST_ASSERT_NOW(label, clk, rst_n, a, b)
`endif

`endif

FILE: rtl/rbst_pkg.sv
package rbst_pkg;

    localparam int Q_W = 32;
    localparam int DIFF_W = Q_W + 1;
    localparam int THR_W = 17;
    localparam int STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES = Q_W / STEPS_PER_STAGE;
    // stage1 + stage2 + divider stages + saturate/order stage
    localparam int AXIS_LAT = DIV_STAGES + 3;

    localparam logic signed [Q_W-1:0] T_MAX = 32'sh7fff_ffff;
    localparam logic signed [Q_W-1:0] T_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic                  par;
        logic                  outside;
        logic signed [Q_W-1:0] t0;
        logic signed [Q_W-1:0] t1;
    } axis_res_t;

endpackage

FILE: rtl/rbst_axis.sv
module rbst_axis import rbst_pkg::*; (
    input  logic                  aclk,
    input  logic                  en,
    input  logic signed [Q_W-1:0] lo,
    input  logic signed [Q_W-1:0] hi,
    input  logic signed [Q_W-1:0] org,
    input  logic signed [Q_W-1:0] dir,
    input  logic [THR_W-1:0]      thr,
    output axis_res_t             res
);

    // stage 1: differences, direction magnitude, parallel and slab checks
    logic signed [DIFF_W-1:0] dlo_reg, dhi_reg;
    logic [Q_W-1:0]           dmag_reg;
    logic                     dneg_reg, par1_reg, outs1_reg;

    logic signed [DIFF_W-1:0] dlo_next, dhi_next;
    logic [Q_W-1:0]           dmag_next;

    always_comb begin
        dlo_next = DIFF_W'(lo) - DIFF_W'(org);
        dhi_next = DIFF_W'(hi) - DIFF_W'(org);
        dmag_next = dir[Q_W-1] ? Q_W'(-dir) : Q_W'(dir);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dlo_reg   <= dlo_next;
            dhi_reg   <= dhi_next;
            dmag_reg  <= dmag_next;
            dneg_reg  <= dir[Q_W-1];
            par1_reg  <= (dir == '0) || (dmag_next < Q_W'(thr));
            outs1_reg <= (org < lo) || (org > hi);
        end
    end

    // divider pipeline, index 0 is the stage 2 output
    logic [DIFF_W-1:0] rem_reg [0:DIV_STAGES][2];
    logic [Q_W-1:0]    q_reg   [0:DIV_STAGES][2];
    logic              neg_reg [0:DIV_STAGES][2];
    logic              ovf_reg [0:DIV_STAGES][2];
    logic [Q_W-1:0]    dm_reg  [0:DIV_STAGES];
    logic              par_reg [0:DIV_STAGES];
    logic              outs_reg[0:DIV_STAGES];

    // stage 2: numerator magnitude (diff << 16) and overflow of the top part
    logic [DIFF_W-1:0]     amag_next [2];
    logic [DIFF_W+15:0]    nmag_next [2];

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            if (k == 0)
                amag_next[k] = dlo_reg[DIFF_W-1] ? DIFF_W'(-dlo_reg) : DIFF_W'(dlo_reg);
            else
                amag_next[k] = dhi_reg[DIFF_W-1] ? DIFF_W'(-dhi_reg) : DIFF_W'(dhi_reg);
            nmag_next[k] = {amag_next[k], 16'd0};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 2; k++) begin
                rem_reg[0][k] <= DIFF_W'(nmag_next[k][DIFF_W+15:Q_W]);
                q_reg[0][k]   <= nmag_next[k][Q_W-1:0];
                ovf_reg[0][k] <= Q_W'(nmag_next[k][DIFF_W+15:Q_W]) >= dmag_reg;
            end
            neg_reg[0][0] <= dlo_reg[DIFF_W-1] ^ dneg_reg;
            neg_reg[0][1] <= dhi_reg[DIFF_W-1] ^ dneg_reg;
            dm_reg[0]     <= dmag_reg;
            par_reg[0]    <= par1_reg;
            outs_reg[0]   <= outs1_reg;
        end
    end

    for (genvar g = 1; g <= DIV_STAGES; g++) begin : g_div
        logic [DIFF_W-1:0] r [2];
        logic [Q_W-1:0]    q [2];

        always_comb begin
            for (int k = 0; k < 2; k++) begin
                r[k] = rem_reg[g-1][k];
                q[k] = q_reg[g-1][k];
                for (int s = 0; s < STEPS_PER_STAGE; s++) begin
                    r[k] = {r[k][DIFF_W-2:0], q[k][Q_W-1]};
                    q[k] = {q[k][Q_W-2:0], 1'b0};
                    if (r[k] >= {1'b0, dm_reg[g-1]}) begin
                        r[k] = r[k] - {1'b0, dm_reg[g-1]};
                        q[k][0] = 1'b1;
                    end
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int k = 0; k < 2; k++) begin
                    rem_reg[g][k] <= r[k];
                    q_reg[g][k]   <= q[k];
                    neg_reg[g][k] <= neg_reg[g-1][k];
                    ovf_reg[g][k] <= ovf_reg[g-1][k];
                end
                dm_reg[g]   <= dm_reg[g-1];
                par_reg[g]  <= par_reg[g-1];
                outs_reg[g] <= outs_reg[g-1];
            end
        end
    end

    // last stage: sign, saturation, ordering
    logic signed [Q_W-1:0] t_next [2];
    logic [Q_W-1:0]        qf;
    axis_res_t             res_reg, res_next;

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            qf = q_reg[DIV_STAGES][k];
            if (neg_reg[DIV_STAGES][k]) begin
                if (ovf_reg[DIV_STAGES][k] || (qf > 32'h8000_0000))
                    t_next[k] = T_MIN;
                else
                    t_next[k] = Q_W'(-qf);
            end else begin
                if (ovf_reg[DIV_STAGES][k] || qf[Q_W-1])
                    t_next[k] = T_MAX;
                else
                    t_next[k] = Q_W'(qf);
            end
        end
        res_next.par     = par_reg[DIV_STAGES];
        res_next.outside = outs_reg[DIV_STAGES];
        if (t_next[0] > t_next[1]) begin
            res_next.t0 = t_next[1];
            res_next.t1 = t_next[0];
        end else begin
            res_next.t0 = t_next[0];
            res_next.t1 = t_next[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en)
            res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

FILE: rtl/ray_box_slab_test.sv
// Ray versus axis-aligned box test by the slab method, signed Q16.16.
// s_ channel: one box and one ray per item (twelve 32-bit fields in tdata).
// m_ channel: one result item per input item, bit 0 of tdata is hit.
// cfg channel: writes parallel_threshold (17 bits), always ready; write it
// only while no item is in flight. Reset value is 1.
// Pipeline: an accepted item passes 19 register stages per axis unit, one fold
// stage and one output register before it reaches m_tvalid. The per-axis
// divider resolves two quotient bits per stage over 16 stages.
// Throughput: one item per cycle unless the output stalls, all stages advance together.
// Stall: while m_tvalid is high and m_tready low the whole pipeline holds,
// s_tready drops and nothing is lost or repeated.
// Reset (aresetn low, synchronous) clears all valid bits and sets the
// threshold back to 1; results in flight are dropped.
module ray_box_slab_test import rbst_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    // ray_origin_x, ray_origin_y, ray_origin_z, ray_dir_x, ray_dir_y, ray_dir_z
    input  logic [12*Q_W-1:0]  s_tdata,
    output logic               m_tvalid,
    input  logic               m_tready,
    // hit, then 7 zero bits
    output logic [7:0]         m_tdata,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [THR_W-1:0]   cfg_data
);

`include "ray_box_slab_test_assert.svh"

    logic             en;
    logic [THR_W-1:0] thr_reg;
    logic             vld_reg [0:AXIS_LAT-1];
    logic             fold_vld_reg, m_tvalid_reg, m_hit_reg;
    axis_res_t        ax [3];

    assign en        = !m_tvalid_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {7'd0, m_hit_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn)
            thr_reg <= THR_W'(1);
        else if (cfg_valid)
            thr_reg <= cfg_data;
    end

    for (genvar a = 0; a < 3; a++) begin : g_axis
        rbst_axis u_axis (
            .aclk (aclk),
            .en   (en),
            .lo   (s_tdata[Q_W*a +: Q_W]),
            .hi   (s_tdata[Q_W*(3+a) +: Q_W]),
            .org  (s_tdata[Q_W*(6+a) +: Q_W]),
            .dir  (s_tdata[Q_W*(9+a) +: Q_W]),
            .thr  (thr_reg),
            .res  (ax[a])
        );
    end

    // fold across axes: near is max of entries, far is min of exits
    logic signed [Q_W-1:0] near_next, far_next, near_reg, far_reg;
    logic                  miss_next, miss_reg;

    always_comb begin
        near_next = T_MIN;
        far_next  = T_MAX;
        miss_next = 1'b0;
        for (int a = 0; a < 3; a++) begin
            if (ax[a].par) begin
                miss_next = miss_next | ax[a].outside;
            end else begin
                if (ax[a].t0 > near_next)
                    near_next = ax[a].t0;
                if (ax[a].t1 < far_next)
                    far_next = ax[a].t1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            near_reg  <= near_next;
            far_reg   <= far_next;
            miss_reg  <= miss_next;
            m_hit_reg <= !miss_reg && !(near_reg > far_reg) && !far_reg[Q_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < AXIS_LAT; i++)
                vld_reg[i] <= 1'b0;
            fold_vld_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < AXIS_LAT; i++)
                vld_reg[i] <= vld_reg[i-1];
            fold_vld_reg <= vld_reg[AXIS_LAT-1];
            m_tvalid_reg <= fold_vld_reg;
        end
    end

    `RBST_ASSERT_NEXT(a_accept_enters, aclk, aresetn, s_tvalid && s_tready, vld_reg[0])
    `RBST_ASSERT_NEXT(a_stall_holds_fold, aclk, aresetn, !en, $stable(fold_vld_reg))
    `RBST_ASSERT_NEXT(a_fold_to_out, aclk, aresetn, en && fold_vld_reg, m_tvalid_reg)

endmodule

FILE: test/ray_box_slab_checker.sv
module ray_box_slab_checker import rbst_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [12*Q_W-1:0] s_tdata,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [7:0]        m_tdata,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [THR_W-1:0]  cfg_data,
    output int                fail_count,
    output int                pending
);
    logic [THR_W-1:0] thresh;
    logic [7:0] hit_q[$];

    function automatic longint sat_dist(longint corner, longint org, longint dir);
        longint num;
        longint q;
        num = (corner - org) * 65536;
        q = num / dir;
        if (q > 64'sd2147483647) return 64'sd2147483647;
        if (q < -64'sd2147483648) return -64'sd2147483648;
        return q;
    endfunction

    function automatic logic predict_hit(logic [12*Q_W-1:0] d, logic [THR_W-1:0] thr);
        longint near_t;
        longint far_t;
        longint lo, hi, org, dir, mag, t0, t1, tmp;
        logic hit;
        near_t = -64'sd2147483648;
        far_t = 64'sd2147483647;
        hit = 1'b1;
        for (int a = 0; a < 3; a++) begin
            lo = longint'($signed(d[a*32 +: 32]));
            hi = longint'($signed(d[(3+a)*32 +: 32]));
            org = longint'($signed(d[(6+a)*32 +: 32]));
            dir = longint'($signed(d[(9+a)*32 +: 32]));
            mag = dir < 0 ? -dir : dir;
            if (dir == 0 || mag < longint'(thr)) begin
                if (org < lo || org > hi) hit = 1'b0;
            end else begin
                t0 = sat_dist(lo, org, dir);
                t1 = sat_dist(hi, org, dir);
                if (t0 > t1) begin
                    tmp = t0; t0 = t1; t1 = tmp;
                end
                if (t0 > near_t) near_t = t0;
                if (t1 < far_t) far_t = t1;
            end
        end
        if (near_t > far_t || far_t < 0) hit = 1'b0;
        return hit;
    endfunction

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        $display("mismatch: %s got %h expected %h", what, got, want);
        fail_count++;
    endtask

    assign pending = hit_q.size();

    initial fail_count = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            thresh <= 1;
            hit_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (hit_q.size() == 0) report_mismatch("unexpected item", m_tdata, 8'h00);
                else begin
                    logic [7:0] w;
                    w = hit_q.pop_front();
                    if (m_tdata !== w) report_mismatch("hit", m_tdata, w);
                end
            end
            if (s_tvalid && s_tready)
                hit_q.push_back({7'b0, predict_hit(s_tdata, thresh)});
            if (cfg_valid && cfg_ready) thresh <= cfg_data;
        end
    end
endmodule

FILE: test/tb_ray_box_slab_test.sv
module tb_ray_box_slab_test;
    import rbst_pkg::*;

    logic              aclk = 0;
    logic              aresetn = 0;
    logic              s_tvalid = 0;
    logic              s_tready;
    logic [12*Q_W-1:0] s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 0;
    logic [7:0]        m_tdata;
    logic              cfg_valid = 0;
    logic              cfg_ready;
    logic [THR_W-1:0]  cfg_data = '0;
    int                fail_count;
    int                pending;
    int                idle_cycles = 0;
    int                rx_wait = 0;
    localparam int     WATCHDOG = 2000;

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    ray_box_slab_test u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    ray_box_slab_checker u_chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    // receiver stalls at random after each item it takes
    always @(posedge aclk) begin
        int w;
        if (!aresetn) begin
            m_tready <= 0;
            rx_wait <= 0;
        end else if (m_tready) begin
            if (m_tvalid) begin
                w = $urandom_range(0, 4);
                m_tready <= (w == 0);
                rx_wait <= w;
            end
        end else if (rx_wait > 1) begin
            rx_wait <= rx_wait - 1;
        end else begin
            m_tready <= 1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'h8000_0000;
            2: return 32'h7fff_ffff;
            default: return $signed($urandom_range(0, 40 << 16)) - (20 << 16);
        endcase
    endfunction

    function automatic logic [31:0] rand_dir();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return $urandom();
            2: return $signed($urandom_range(0, 4)) - 2;
            3: return 32'h8000_0000;
            default: return $signed($urandom_range(0, 4 << 16)) - (2 << 16);
        endcase
    endfunction

    task automatic send_item(logic [12*Q_W-1:0] d);
        int w;
        w = $urandom_range(0, 4);
        if (w > 0) begin
            s_tvalid <= 0;
            repeat (w) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= d;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_box(logic [31:0] lo[3], logic [31:0] hi[3],
                            logic [31:0] o[3], logic [31:0] dr[3]);
        logic [12*Q_W-1:0] d;
        for (int a = 0; a < 3; a++) begin
            d[a*32 +: 32] = lo[a];
            d[(3+a)*32 +: 32] = hi[a];
            d[(6+a)*32 +: 32] = o[a];
            d[(9+a)*32 +: 32] = dr[a];
        end
        send_item(d);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (pending != 0) @(posedge aclk);
        repeat (AXIS_LAT + 6) @(posedge aclk);
    endtask

    task automatic write_thresh(logic [THR_W-1:0] v);
        cfg_valid <= 1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
    endtask

    task automatic send_random(int n);
        logic [31:0] lo[3], hi[3], o[3], dr[3];
        logic [31:0] c, e;
        for (int i = 0; i < n; i++) begin
            for (int a = 0; a < 3; a++) begin
                c = rand_coord();
                e = $urandom_range(0, 8 << 16);
                lo[a] = ($urandom_range(0, 9) == 0) ? rand_coord() : c - e;
                hi[a] = ($urandom_range(0, 9) == 0) ? rand_coord() : c + e;
                o[a] = rand_coord();
                dr[a] = rand_dir();
                // aim most rays at the box center
                if ($urandom_range(0, 2) != 0 && $signed(dr[a]) != 0 &&
                    $signed(dr[a]) != 32'sh8000_0000)
                    dr[a] = ($signed(c) < $signed(o[a])) ?
                            -($signed(dr[a]) < 0 ? -dr[a] : dr[a]) :
                            ($signed(dr[a]) < 0 ? -dr[a] : dr[a]);
            end
            send_box(lo, hi, o, dr);
        end
    endtask

    logic [THR_W-1:0] thr_set[6] = '{17'd0, 17'd65536, 17'd131071, 17'd1, 17'd300, 17'd32768};

    initial begin
        logic [31:0] lo[3], hi[3], o[3], dr[3];
        repeat (12) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: simple hit, miss behind, parallel inside and outside
        lo = '{32'hffff_0000, 32'hffff_0000, 32'hffff_0000};
        hi = '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000};
        o = '{32'hfffb_0000, 0, 0};
        dr = '{32'h0001_0000, 0, 0};
        send_box(lo, hi, o, dr);
        dr = '{32'hffff_0000, 0, 0};
        send_box(lo, hi, o, dr);
        o = '{0, 32'h0005_0000, 0};
        dr = '{32'h0001_0000, 0, 0};
        send_box(lo, hi, o, dr);
        // inverted box on a parallel axis
        lo = '{32'h0001_0000, 32'hffff_0000, 32'hffff_0000};
        hi = '{32'hffff_0000, 32'h0001_0000, 32'h0001_0000};
        o = '{0, 0, 0};
        dr = '{0, 32'h0001_0000, 0};
        send_box(lo, hi, o, dr);
        dr = '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000};
        send_box(lo, hi, o, dr);
        // saturated distances with extreme fields
        lo = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        hi = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
        o = '{32'h7fff_ffff, 32'h8000_0000, 0};
        dr = '{32'h0000_0001, 32'h8000_0000, 32'h7fff_ffff};
        send_box(lo, hi, o, dr);
        dr = '{32'hffff_ffff, 32'h0000_0001, 32'h0000_0002};
        send_box(lo, hi, o, dr);
        send_box(hi, lo, lo, hi);
        drain();

        // each threshold, extremes among them; zero threshold with zero direction
        foreach (thr_set[k]) begin
            write_thresh(thr_set[k]);
            lo = '{32'hffff_0000, 32'hffff_0000, 32'hffff_0000};
            hi = '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000};
            o = '{0, 32'h0000_8000, 32'hfffe_0000};
            dr = '{0, 32'h0000_ffff, 32'h0001_0000};
            send_box(lo, hi, o, dr);
            send_random(150);
            // hold off until every result is in
            drain();
        end
        write_thresh(17'd1);
        send_random(50);
        drain();

        if (fail_count == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end
endmodule
